// File: design/gcode_line_checksum_framer_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the line framer
// ----------------------------------------------------------------------------
`ifndef GCODE_LINE_CHECKSUM_FRAMER_DEFINES_SVH
`define GCODE_LINE_CHECKSUM_FRAMER_DEFINES_SVH

// checked only out of reset
`define GCLF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define GCLF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/gclf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gclf_pkg
// shared constants, types and the crc-16 byte update for the line framer
// ----------------------------------------------------------------------------
package gclf_pkg;

    localparam int LINE_DEPTH = 128;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
    localparam int IDX_W      = 7;
    localparam int CHECK_W    = 17;
    localparam int DIGITS_W   = 3;

    localparam logic [1:0] ACT_OFFER   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [DIGITS_W-1:0] CRC_DIGITS    = 3'd5;
    localparam logic [DIGITS_W-1:0] XOR_DIGITS_HI = 3'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        char_in;
        logic [IDX_W-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic              accepted;
        logic              command_ready;
        logic [FILL_W-1:0] command_length;
        logic              read_hit;
    } result_meta_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_cmd_t;

    // msb-first crc-16 over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: design/gclf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gclf_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gclf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: design/gclf_parser.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gcode_line_checksum_framer_defines.svh"
// ----------------------------------------------------------------------------
// gclf_parser
// line parse state, xor checksum, crc-16 and fill count; drives the line ram
// ----------------------------------------------------------------------------
module gclf_parser (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire gclf_pkg::in_item_t    item,
    output gclf_pkg::ram_cmd_t         ram_cmd,
    output gclf_pkg::result_meta_t     meta
);

    localparam logic [2:0] ST_WAIT   = 3'd0;
    localparam logic [2:0] ST_LINENO = 3'd1;
    localparam logic [2:0] ST_CMD    = 3'd2;
    localparam logic [2:0] ST_QUOTE  = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_HELD   = 3'd5;

    localparam logic [gclf_pkg::FILL_W-1:0] DEPTH_F =
        gclf_pkg::FILL_W'(gclf_pkg::LINE_DEPTH);

    logic [2:0]                      state_reg, state_next;
    logic [7:0]                      xor_reg, xor_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [gclf_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [gclf_pkg::CHECK_W-1:0]    check_reg, check_next;
    logic [gclf_pkg::DIGITS_W-1:0]   digits_reg, digits_next;

    logic [7:0]                      c;
    logic                            is_digit, is_eol;
    logic                            take, start, put_lf, good;
    logic                            offer_ok;
    logic [7:0]                      xor_base;
    logic [15:0]                     crc_base;
    logic [gclf_pkg::FILL_W-1:0]     fill_base;
    logic [gclf_pkg::CHECK_W-1:0]    digit_val;
    logic                            wr_en;
    logic [gclf_pkg::ADDR_W-1:0]     wr_addr;
    logic [7:0]                      wr_data;

    assign c         = item.char_in;
    assign is_digit  = (c >= gclf_pkg::CH_ZERO) && (c <= gclf_pkg::CH_NINE);
    assign is_eol    = (c == gclf_pkg::CH_LF) || (c == gclf_pkg::CH_CR);
    assign digit_val = gclf_pkg::CHECK_W'(c - gclf_pkg::CH_ZERO);

    always_comb begin
        state_next    = state_reg;
        check_next    = check_reg;
        digits_next   = digits_reg;
        take          = 1'b0;
        start         = 1'b0;
        put_lf        = 1'b0;
        good          = 1'b0;
        offer_ok      = 1'b0;

        if (accept) begin
            unique case (item.action)
                gclf_pkg::ACT_OFFER: begin
                    if (state_reg != ST_HELD) begin
                        offer_ok = 1'b1;
                        unique case (state_reg) inside
                            ST_WAIT: begin
                                if (c == gclf_pkg::CH_N) begin
                                    state_next = ST_LINENO;
                                    start      = 1'b1;
                                    take       = 1'b1;
                                end
                            end
                            ST_LINENO, ST_CMD: begin
                                if (state_reg == ST_LINENO && is_digit) begin
                                    take = 1'b1;
                                end else if (c == gclf_pkg::CH_STAR) begin
                                    state_next  = ST_CHECK;
                                    check_next  = '0;
                                    digits_next = '0;
                                end else if (is_eol) begin
                                    state_next = ST_WAIT;
                                end else begin
                                    state_next = (c == gclf_pkg::CH_QUOTE) ? ST_QUOTE : ST_CMD;
                                    take       = 1'b1;
                                end
                            end
                            ST_QUOTE: begin
                                if (is_eol) begin
                                    state_next = ST_WAIT;
                                end else begin
                                    if (c == gclf_pkg::CH_QUOTE) begin
                                        state_next = ST_CMD;
                                    end
                                    take = 1'b1;
                                end
                            end
                            ST_CHECK: begin
                                if (is_eol) begin
                                    if (fill_reg >= DEPTH_F) begin
                                        state_next = ST_WAIT;
                                    end else begin
                                        put_lf = 1'b1;
                                        good = ((digits_reg >= 3'd1)
                                                && (digits_reg <= gclf_pkg::XOR_DIGITS_HI)
                                                && (check_reg == gclf_pkg::CHECK_W'(xor_reg)))
                                            || ((digits_reg == gclf_pkg::CRC_DIGITS)
                                                && (check_reg == gclf_pkg::CHECK_W'(crc_reg)));
                                        state_next = good ? ST_HELD : ST_WAIT;
                                    end
                                end else if (is_digit && digits_reg < gclf_pkg::CRC_DIGITS) begin
                                    // times ten as the sum of two shifts, plus the digit
                                    check_next  = gclf_pkg::CHECK_W'({check_reg, 3'b000})
                                                + gclf_pkg::CHECK_W'({check_reg, 1'b0})
                                                + digit_val;
                                    digits_next = digits_reg + 3'd1;
                                end else begin
                                    state_next = ST_WAIT;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                gclf_pkg::ACT_READ: begin
                end
                gclf_pkg::ACT_RELEASE: begin
                    state_next = ST_WAIT;
                end
                default: begin
                end
            endcase
        end
    end

    // a new line restarts both checks and the fill pointer
    assign xor_base  = start ? 8'h00 : xor_reg;
    assign crc_base  = start ? 16'h0000 : crc_reg;
    assign fill_base = start ? '0 : fill_reg;

    always_comb begin
        xor_next  = xor_reg;
        crc_next  = crc_reg;
        fill_next = fill_reg;
        wr_en     = 1'b0;
        wr_addr   = fill_base[gclf_pkg::ADDR_W-1:0];
        wr_data   = put_lf ? gclf_pkg::CH_LF : c;
        if (take) begin
            xor_next = xor_base ^ c;
            crc_next = gclf_pkg::crc_byte(crc_base, c);
        end
        if ((take || put_lf) && fill_base < DEPTH_F) begin
            wr_en     = 1'b1;
            fill_next = fill_base + 1'b1;
        end
    end

    assign ram_cmd.wr_en   = wr_en;
    assign ram_cmd.wr_addr = wr_addr;
    assign ram_cmd.wr_data = wr_data;
    assign ram_cmd.rd_en   = accept && (item.action == gclf_pkg::ACT_READ);
    assign ram_cmd.rd_addr = item.read_index[gclf_pkg::ADDR_W-1:0];

    assign meta.accepted       = offer_ok;
    assign meta.command_ready  = (state_next == ST_HELD);
    assign meta.command_length = (state_next == ST_HELD) ? fill_next : '0;
    assign meta.read_hit       = ram_cmd.rd_en
        && (gclf_pkg::FILL_W'(item.read_index) < DEPTH_F);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_WAIT;
            xor_reg    <= '0;
            crc_reg    <= '0;
            fill_reg   <= '0;
            check_reg  <= '0;
            digits_reg <= '0;
        end else begin
            state_reg  <= state_next;
            xor_reg    <= xor_next;
            crc_reg    <= crc_next;
            fill_reg   <= fill_next;
            check_reg  <= check_next;
            digits_reg <= digits_next;
        end
    end

    `GCLF_ASSERT(gclf_held_has_line, (state_reg == ST_HELD) |-> (fill_reg != '0), "held line is empty")
    `GCLF_ASSERT(gclf_wr_in_range, wr_en |-> (fill_base < DEPTH_F), "line write past depth")
    `GCLF_ASSERT(gclf_held_frozen, (state_reg == ST_HELD && !(accept && item.action == gclf_pkg::ACT_RELEASE)) |=> ($stable(fill_reg) && $stable(xor_reg) && $stable(crc_reg)), "held line changed")

endmodule
`default_nettype wire

// File: design/gclf_out.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gcode_line_checksum_framer_defines.svh"
// ----------------------------------------------------------------------------
// gclf_out
// result stage: a ram read stage for the ram read data, then an output register
// ----------------------------------------------------------------------------
module gclf_out (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    accept,
    input  wire gclf_pkg::result_meta_t  meta,
    input  wire logic [7:0]              rd_data,
    output logic                         s_tready,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [23:0]                  m_tdata
);

    logic                   p1_valid_reg, p1_valid_next;
    gclf_pkg::result_meta_t p1_meta_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [23:0]            m_data_reg;
    logic                   p1_move;
    logic [7:0]             read_byte;

    // ram data stays put while stalled, as no read is issued then
    assign p1_move   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !p1_valid_reg || p1_move;
    assign read_byte = p1_meta_reg.read_hit ? rd_data : 8'h00;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (p1_move) begin
            m_valid_next  = 1'b1;
            p1_valid_next = 1'b0;
        end
        if (accept) begin
            p1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_meta_reg <= meta;
        end
        if (p1_move) begin
            m_data_reg <= {6'b0, read_byte, 8'(p1_meta_reg.command_length),
                           p1_meta_reg.command_ready, p1_meta_reg.accepted};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `GCLF_ASSERT_ALWAYS(gclf_out_reset, (!aresetn) |=> (!p1_valid_reg && !m_valid_reg), "result stage not cleared by reset")
    `GCLF_ASSERT(gclf_p1_kept, (p1_valid_reg && !p1_move) |=> p1_valid_reg, "pending result lost")
    `GCLF_ASSERT(gclf_m_held, (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)), "result beat changed while stalled")

endmodule
`default_nettype wire

// File: design/gcode_line_checksum_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcode_line_checksum_framer
// frames n-numbered g-code lines with xor or crc-16 check into a line ram
// ----------------------------------------------------------------------------
//  channel  dir  tdata (lsb first)                                 tuser
//  s_       in   char_in[7:0] read_index[14:8], zero to 16 bits    action[1:0]
//  m_       out  accepted[0] command_ready[1] command_length[9:2]  -
//                read_data[17:10], zero to 24 bits
//
//  one beat per cycle in while s_tready is high; each beat gives one result beat
//  parse state, checks and line ram write are settled in the accepting cycle
//  read data is registered by the line ram, then by the output register
//  s_tready drops only when both the ram read stage and the output are full
//  reset clears parse and handshake state; the line ram is not cleared
// ----------------------------------------------------------------------------
module gcode_line_checksum_framer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // char_in[7:0], read_index[14:8]
    input  wire logic [1:0]  s_tuser,  // action[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // accepted, command_ready, command_length, read_data
);

    gclf_pkg::in_item_t     item;
    gclf_pkg::ram_cmd_t     ram_cmd;
    gclf_pkg::result_meta_t meta;
    logic                   accept;
    logic [7:0]             rd_data;

    assign accept          = s_tvalid && s_tready;
    assign item.action     = s_tuser;
    assign item.char_in    = s_tdata[7:0];
    assign item.read_index = s_tdata[14:8];

    gclf_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (item),
        .ram_cmd (ram_cmd),
        .meta    (meta)
    );

    gclf_ram #(
        .WIDTH (8),
        .DEPTH (gclf_pkg::LINE_DEPTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_cmd.wr_en),
        .wr_addr (ram_cmd.wr_addr),
        .wr_data (ram_cmd.wr_data),
        .rd_en   (ram_cmd.rd_en),
        .rd_addr (ram_cmd.rd_addr),
        .rd_data (rd_data)
    );

    gclf_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .meta     (meta),
        .rd_data  (rd_data),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams serial characters, buffer reads and releases into the g-code line
// framer; every result beat is checked against a directed row or an in-bench
// prediction of the parser, the xor and crc-16 checks and the line buffer
// ----------------------------------------------------------------------------
module testbench;
    import gclf_pkg::*;

    localparam logic [1:0] ACT_IDLE = 2'd3;
    localparam int GAP_MAX         = 18;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_EVERY  = 800;
    localparam int IDLE_LIMIT      = 4000;
    localparam int BEAT_TARGET     = 1850;
    localparam int DRAIN_CYCLES    = 12;
    localparam int N_DIRECTED      = 25;

    typedef enum logic [2:0] {
        PS_WAIT   = 3'd0,
        PS_LINENO = 3'd1,
        PS_CMD    = 3'd2,
        PS_QUOTE  = 3'd3,
        PS_CHECK  = 3'd4,
        PS_HELD   = 3'd5
    } parse_t;

    typedef struct packed {
        logic       accepted;
        logic       command_ready;
        logic [7:0] command_length;
        logic [7:0] read_data;
    } framer_resp_t;

    typedef struct packed {
        logic [1:0]   action;
        logic [7:0]   char_in;
        logic [6:0]   read_index;
        logic         typed;
        framer_resp_t resp;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // char_in[7:0], read_index[14:8]
    logic [1:0]  s_tuser;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // accepted, command_ready, command_length, read_data

    gcode_line_checksum_framer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted framer state
    parse_t      line_state;
    logic [7:0]  line_xor;
    logic [15:0] line_crc;
    int          line_fill;
    logic [16:0] check_value;
    int          check_count;
    logic [7:0]  line_copy [LINE_DEPTH];
    int          written_top;   // entries below this index have been written

    framer_resp_t responses_due [$];
    stim_row_t    directed_rows [N_DIRECTED];

    int errors       = 0;
    int beats_sent   = 0;
    int results_seen = 0;
    int lines_held   = 0;
    int deepest_read = 0;
    int hold_offs    = 0;
    int idle_cycles  = 0;
    bit burst        = 1'b0;
    bit hold_off_req = 1'b0;

    function automatic logic [15:0] crc16_next(logic [15:0] crc, logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_eol(logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    function automatic void put_byte(logic [7:0] c);
        line_copy[line_fill] = c;
        line_fill++;
        if (line_fill > written_top) begin
            written_top = line_fill;
        end
    endfunction

    // folds a line character into both checks; stored only while room is left
    function automatic void store_char(logic [7:0] c);
        line_xor = line_xor ^ c;
        line_crc = crc16_next(line_crc, c);
        if (line_fill < LINE_DEPTH) begin
            put_byte(c);
        end
    endfunction

    function automatic void command_char(logic [7:0] c);
        if (c == CH_STAR) begin
            line_state  = PS_CHECK;
            check_value = '0;
            check_count = 0;
        end else if (is_eol(c)) begin
            line_state = PS_WAIT;
        end else begin
            if (c == CH_QUOTE) begin
                line_state = PS_QUOTE;
            end
            store_char(c);
        end
    endfunction

    function automatic void check_char(logic [7:0] c);
        logic good;
        if (is_eol(c)) begin
            if (line_fill >= LINE_DEPTH) begin
                line_state = PS_WAIT;
            end else begin
                put_byte(CH_LF);
                good = (check_count >= 1 && check_count <= XOR_DIGITS_HI
                        && check_value == {9'd0, line_xor})
                    || (check_count == CRC_DIGITS && check_value == {1'b0, line_crc});
                line_state = good ? PS_HELD : PS_WAIT;
                if (good) begin
                    lines_held++;
                end
            end
        end else if (is_digit(c) && check_count < CRC_DIGITS) begin
            check_value = 17'(check_value * 10 + (c - CH_ZERO));
            check_count++;
        end else begin
            line_state = PS_WAIT;
        end
    endfunction

    function automatic void offer_char(logic [7:0] c);
        case (line_state)
            PS_WAIT: begin
                if (c == CH_N) begin
                    line_state = PS_LINENO;
                    line_xor   = '0;
                    line_crc   = '0;
                    line_fill  = 0;
                    store_char(c);
                end
            end
            PS_LINENO: begin
                if (is_digit(c)) begin
                    store_char(c);
                end else begin
                    line_state = PS_CMD;
                    command_char(c);
                end
            end
            PS_CMD: begin
                command_char(c);
            end
            PS_QUOTE: begin
                if (is_eol(c)) begin
                    line_state = PS_WAIT;
                end else begin
                    if (c == CH_QUOTE) begin
                        line_state = PS_CMD;
                    end
                    store_char(c);
                end
            end
            PS_CHECK: begin
                check_char(c);
            end
            default: ;
        endcase
    endfunction

    function automatic framer_resp_t predict_framer_beat(logic [1:0] act, logic [7:0] c,
                                                         logic [6:0] idx);
        framer_resp_t r;
        r = '0;
        case (act)
            ACT_OFFER: begin
                if (line_state != PS_HELD) begin
                    offer_char(c);
                    r.accepted = 1'b1;
                end
            end
            ACT_READ: begin
                r.read_data = line_copy[idx];
            end
            ACT_RELEASE: begin
                line_state = PS_WAIT;
            end
            default: ;
        endcase
        if (line_state == PS_HELD) begin
            r.command_ready  = 1'b1;
            r.command_length = line_fill[7:0];
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat went in
    task automatic send_beat(input logic [1:0] act, input logic [7:0] c,
                             input logic [6:0] idx, input logic typed,
                             input framer_resp_t typed_resp);
        int gap;
        framer_resp_t r;
        gap = burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, idx, c};
        do @(posedge aclk); while (s_tready !== 1'b1);
        r = predict_framer_beat(act, c, idx);
        responses_due.push_back(typed ? typed_resp : r);
        if (act != ACT_IDLE) begin
            beats_sent++;
        end
        if (act == ACT_READ && idx > deepest_read) begin
            deepest_read = idx;
        end
        @(negedge aclk);
    endtask

    task automatic send_char(input logic [7:0] c);
        send_beat(ACT_OFFER, c, 7'($urandom), 1'b0, '0);
    endtask

    task automatic send_read();
        if (written_top > 0) begin
            send_beat(ACT_READ, 8'($urandom), 7'($urandom_range(0, written_top - 1)),
                      1'b0, '0);
        end
    endtask

    task automatic send_random_line();
        logic [7:0]  text [$];
        logic [7:0]  c;
        logic [7:0]  sum_x;
        logic [15:0] sum_crc;
        bit          in_quote;
        int          body, pick, ndig, need, val;
        text     = {};
        in_quote = 1'b0;
        sum_x    = '0;
        sum_crc  = '0;
        text.push_back(CH_N);
        repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        // now and then a line whose length is near or past the buffer depth
        if ($urandom_range(0, 99) < 6) begin
            body = $urandom_range(LINE_DEPTH - 10, LINE_DEPTH + 8) - text.size();
        end else begin
            body = $urandom_range(0, 24);
        end
        repeat (body) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                c        = CH_QUOTE;
                in_quote = !in_quote;
            end else if (pick < 10) begin
                c = 8'($urandom);
            end else begin
                c = 8'($urandom_range(8'h20, 8'h7E));
                if (c == CH_QUOTE || (c == CH_STAR && !in_quote)) begin
                    c = 8'h47;
                end
            end
            text.push_back(c);
        end
        if (in_quote) begin
            text.push_back(CH_QUOTE);
        end
        foreach (text[i]) begin
            sum_x   = sum_x ^ text[i];
            sum_crc = crc16_next(sum_crc, text[i]);
        end
        text.push_back(CH_STAR);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            need = (sum_x >= 100) ? 3 : (sum_x >= 10) ? 2 : 1;
            ndig = $urandom_range(need, XOR_DIGITS_HI);
            val  = sum_x;
        end else if (pick < 85) begin
            ndig = CRC_DIGITS;
            val  = sum_crc;
        end else begin
            // wrong value, or too few, four or six digits
            ndig = $urandom_range(0, 6);
            val  = $urandom_range(0, 99999);
        end
        for (int k = ndig - 1; k >= 0; k--) begin
            text.push_back(8'(CH_ZERO + (val / (10 ** k)) % 10));
        end
        if (pick >= 95) begin
            text.push_back(8'($urandom));
        end
        if ($urandom_range(0, 24) != 0) begin
            text.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom));
        end
        foreach (text[i]) begin
            if ($urandom_range(0, 199) == 0) begin
                send_beat(ACT_RELEASE, 8'($urandom), 7'($urandom), 1'b0, '0);
            end
            send_char(text[i]);
        end
        if (line_state == PS_HELD) begin
            repeat ($urandom_range(0, 4)) send_read();
            if ($urandom_range(0, 2) == 0) begin
                send_char(8'($urandom));
            end
            if ($urandom_range(0, 9) == 0) begin
                send_beat(ACT_IDLE, 8'($urandom), 7'($urandom), 1'b0, '0);
            end
            send_beat(ACT_RELEASE, 8'($urandom), 7'($urandom), 1'b0, '0);
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_read();
            end else if (pick < 20) begin
                send_beat(ACT_RELEASE, 8'($urandom), 7'($urandom), 1'b0, '0);
            end else if (pick < 23) begin
                send_beat(ACT_IDLE, 8'($urandom), 7'($urandom), 1'b0, '0);
            end
        end
    endtask

    initial begin
        int next_hold_off;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_OFFER;
        line_state  = PS_WAIT;
        line_xor    = '0;
        line_crc    = '0;
        line_fill   = 0;
        check_value = '0;
        check_count = 0;
        written_top = 0;
        next_hold_off = 700;

        // "N1G" xors to 56; the held length counts the appended newline
        directed_rows = '{
            '{ACT_RELEASE, 8'h00,    7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00}},
            '{ACT_IDLE,    8'hFF,    7'h7F,  1'b1, '{1'b0, 1'b0, 8'd0, 8'h00}},
            '{ACT_OFFER,   8'h78,    7'd0,   1'b1, '{1'b1, 1'b0, 8'd0, 8'h00}},
            '{ACT_OFFER,   CH_N,     7'd0,   1'b0, '0},
            '{ACT_OFFER,   8'h31,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   8'h47,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_STAR,  7'd0,   1'b0, '0},
            '{ACT_OFFER,   8'h35,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   8'h36,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_LF,    7'd0,   1'b1, '{1'b1, 1'b1, 8'd4, 8'h00}},
            '{ACT_OFFER,   8'h5A,    7'd0,   1'b1, '{1'b0, 1'b1, 8'd4, 8'h00}},
            '{ACT_READ,    8'h00,    7'd3,   1'b1, '{1'b0, 1'b1, 8'd4, CH_LF}},
            '{ACT_READ,    8'h00,    7'd0,   1'b1, '{1'b0, 1'b1, 8'd4, CH_N}},
            '{ACT_RELEASE, 8'h00,    7'd0,   1'b1, '{1'b0, 1'b0, 8'd0, 8'h00}},
            '{ACT_OFFER,   CH_N,     7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_QUOTE, 7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_STAR,  7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_LF,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_N,     7'd0,   1'b0, '0},
            '{ACT_OFFER,   8'h39,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_STAR,  7'd0,   1'b0, '0},
            '{ACT_OFFER,   8'h00,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_N,     7'd0,   1'b0, '0},
            '{ACT_OFFER,   8'hFF,    7'd0,   1'b0, '0},
            '{ACT_OFFER,   CH_CR,    7'd0,   1'b0, '0}
        };

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].action, directed_rows[i].char_in,
                      directed_rows[i].read_index, directed_rows[i].typed,
                      directed_rows[i].resp);
        end

        while (beats_sent < BEAT_TARGET) begin
            burst = ($urandom_range(0, 5) == 0);
            if (beats_sent >= next_hold_off) begin
                hold_off_req  = 1'b1;
                next_hold_off = next_hold_off + HOLD_OFF_EVERY;
            end
            send_random_line();
        end
        s_tvalid <= 1'b0;

        while (responses_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("testbench: %0d beats sent, %0d result beats checked, %0d lines held",
                 beats_sent, results_seen, lines_held);
        $display("testbench: deepest buffer read %0d, %0d long receiver hold-offs",
                 deepest_read, hold_offs);
        if (errors == 0 && responses_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // receiver side: random stalls, quiet stretches and the odd long hold-off
    initial begin
        int gap;
        int quiet;
        quiet    = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap          = HOLD_OFF_CYCLES;
                hold_offs++;
            end else if (quiet > 0) begin
                gap = 0;
                quiet--;
            end else begin
                gap = $urandom_range(0, GAP_MAX);
                if ($urandom_range(0, 39) == 0) begin
                    quiet = $urandom_range(10, 60);
                end
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            @(negedge aclk);
        end
    end

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, expected, actual);
        end
    endfunction

    // result beat checking and the no-progress watchdog
    always @(posedge aclk) begin
        framer_resp_t due;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            results_seen++;
            if (responses_due.size() == 0) begin
                errors++;
                $error("result beat with nothing expected, tdata %h", m_tdata);
            end else begin
                due = responses_due.pop_front();
                check_field("accepted", due.accepted, m_tdata[0]);
                check_field("command_ready", due.command_ready, m_tdata[1]);
                check_field("command_length", due.command_length, m_tdata[9:2]);
                check_field("read_data", due.read_data, m_tdata[17:10]);
            end
        end
        if ((s_tvalid === 1'b1 && s_tready === 1'b1)
            || (m_tvalid === 1'b1 && m_tready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule
